// ----- src/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types, constants and tables of the control ramp smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package crs_pkg;

    localparam int NUM_CONTROLS     = 64;
    localparam int IDX_W            = $clog2(NUM_CONTROLS);
    localparam int MAX_BLOCK_FRAMES = 4096;
    localparam int VAL_W            = 32;
    localparam int FL_W             = 16;
    localparam int BLK_W            = 13;
    localparam int LOG_W            = 36;      // unsigned Q5.31
    localparam int NUM_W            = LOG_W + BLK_W;
    localparam int CNT_W            = 6;
    localparam int NFAC             = 30;
    localparam int PADDR_W          = 3;
    localparam logic [FL_W-1:0] RAMP_RESET = 16'd480;

    localparam logic [0:0] REG_RAMP_FRAMES = 1'b0;

    localparam logic KIND_BLOCK = 1'b0;
    localparam logic KIND_SNAP  = 1'b1;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_LIN  = 2'd1,
        MODE_LOG  = 2'd2,
        MODE_RSV  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LIN,
        S_LOG,
        S_LMUL,
        S_DIV,
        S_POST,
        S_EXP,
        S_EXPF,
        S_UPD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] cur;
        logic [VAL_W-1:0] tgt;
        logic [FL_W-1:0]  fl;
    } t_entry;

    typedef logic [NFAC-1:0][31:0] t_fac_tab;

    // 2^(2^-k) in Q2.30, k = 1..30; each the truncated root of the one before
    function automatic t_fac_tab f_fac_tab();
        t_fac_tab    tab;
        logic [63:0] c;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        c = 64'd1 << 31;
        for (int k = 0; k < NFAC; k++) begin
            x = c << 30;
            r = '0;
            b = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            tab[k] = r[31:0];
            c = r;
        end
        return tab;
    endfunction

    localparam t_fac_tab FAC_TAB = f_fac_tab();

    function automatic logic [4:0] f_top_bit(input logic [31:0] x);
        logic [4:0] e;
        e = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                e = 5'(i);
            end
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- src/crs_if.sv -----
// ----------------------------------------------------------------------------
// crs_if
// Item and result channels of the control ramp smoother.
// ----------------------------------------------------------------------------
`default_nettype none

interface crs_in_if import crs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [IDX_W-1:0]  control_index;
    logic [VAL_W-1:0]  published_value;
    logic [1:0]        smoothing_mode;
    logic [BLK_W-1:0]  block_frames;

    modport source (output valid, kind, control_index, published_value,
                    smoothing_mode, block_frames, input ready);
    modport sink   (input valid, kind, control_index, published_value,
                    smoothing_mode, block_frames, output ready);
endinterface

interface crs_out_if import crs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  start_value;
    logic [VAL_W-1:0]  end_value;
    logic              still_ramping;

    modport source (output valid, start_value, end_value, still_ramping,
                    input ready);
    modport sink   (input valid, start_value, end_value, still_ramping,
                    output ready);
endinterface

`default_nettype wire

// ----- src/control_parameter_ramp_smoother_top.sv -----
// ----------------------------------------------------------------------------
// control_parameter_ramp_smoother_top
// Per-control ramp smoother; state table in one synchronous memory.
// ----------------------------------------------------------------------------
// Path, accept edge to result valid, no result stall: READ, FIN for a snap,
//   a rejected block or a block with no ramp pending; READ, LIN, 49-step
//   divider, POST, UPD, FIN for a linear step; a log step has LOG (two
//   31-step log2 squarings) and LMUL for LIN and adds EXP (30 exp2 factor
//   steps) and EXPF. One item at a time; next accept in the cycle after the
//   result loads, which waits while the previous result beat is held.
// Reset: i_rst_n synchronous active low; clears control, valid bits and
//   ramp_frames (480). Table entries not yet written read as zero.
`default_nettype none

module control_parameter_ramp_smoother_top import crs_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    crs_in_if.sink             i_item,
    crs_out_if.source          o_result,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [PADDR_W-1:0]  paddr,
    input  wire [31:0]         pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ---------------- config register ----------------
    logic [FL_W-1:0] r_ramp;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp <= RAMP_RESET;
        end else if (cfg_wr && (paddr[2:2] == REG_RAMP_FRAMES)) begin
            r_ramp <= pwdata[FL_W-1:0];
        end
    end

    assign prdata = (paddr[2:2] == REG_RAMP_FRAMES) ? {16'b0, r_ramp} : 32'b0;

    // ---------------- state and registers ----------------
    t_state r_state, n_state;

    logic              r_in_kind, n_in_kind;
    logic [IDX_W-1:0]  r_in_idx,  n_in_idx;
    logic [VAL_W-1:0]  r_in_val,  n_in_val;
    t_mode             r_in_mode, n_in_mode;
    logic [BLK_W-1:0]  r_in_blk,  n_in_blk;

    logic [VAL_W-1:0]  r_cur, n_cur;
    logic [VAL_W-1:0]  r_tgt, n_tgt;
    logic [FL_W-1:0]   r_fl,  n_fl;       // ramp frames left (divisor)
    logic [BLK_W-1:0]  r_frames, n_frames;
    logic [VAL_W-1:0]  r_start, n_start;
    logic              r_wr, n_wr;
    logic              r_logm, n_logm;
    logic              r_neg, n_neg;
    logic              r_phase, n_phase;

    logic [LOG_W-1:0]  r_lc, n_lc;       // log of current, later log result
    logic [LOG_W-1:0]  r_lt, n_lt;
    logic [31:0]       r_m, n_m;         // log mantissa Q1.31
    logic [30:0]       r_frac, n_frac;
    logic [4:0]        r_e, n_e;
    logic [NUM_W-1:0]  r_dnum, n_dnum;   // dividend in, quotient out
    logic [FL_W-1:0]   r_drem, n_drem;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [31:0]       r_p, n_p;         // exp2 product Q2.30

    logic              r_out_vld;
    logic [VAL_W-1:0]  r_o_start, r_o_end;
    logic              r_o_ramp;

    // ---------------- state memory ----------------
    t_entry               mem [NUM_CONTROLS];
    t_entry               r_rd;
    logic                 r_rd_vld;
    logic [NUM_CONTROLS-1:0] r_vld;
    t_entry               rd_ent;
    logic                 in_acc;
    logic                 fin_go;
    logic                 mem_we;

    assign in_acc = i_item.valid && i_item.ready;
    assign fin_go = (r_state == S_FIN) && (!r_out_vld || o_result.ready);
    assign mem_we = fin_go && r_wr;
    assign rd_ent = r_rd_vld ? r_rd : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_in_idx] <= '{cur: r_cur, tgt: r_tgt, fl: r_fl};
        end
        if (in_acc) begin
            r_rd <= mem[i_item.control_index];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[r_in_idx] <= 1'b1;
            end
            if (in_acc) begin
                r_rd_vld <= r_vld[i_item.control_index];
            end
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (n_wr && (n_fl != '0) && (r_in_kind == KIND_BLOCK)) begin
                    n_state = n_logm ? S_LOG : S_LIN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_LIN:  n_state = S_DIV;
            S_LOG: begin
                if ((r_cnt == CNT_W'(30)) && r_phase) begin
                    n_state = S_LMUL;
                end
            end
            S_LMUL: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = S_POST;
                end
            end
            S_POST: n_state = r_logm ? S_EXP : S_UPD;
            S_EXP: begin
                if (r_cnt == CNT_W'(NFAC - 1)) begin
                    n_state = S_EXPF;
                end
            end
            S_EXPF: n_state = S_UPD;
            S_UPD:  n_state = S_FIN;
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    logic               retgt;
    logic [FL_W-1:0]    fl2;
    logic [VAL_W-1:0]   tgt2;
    logic [32:0]        diff, mag;
    logic [63:0]        sq;
    logic               sq_hi;
    logic [LOG_W-1:0]   lval;
    logic [4:0]         e_t;
    logic [LOG_W-1:0]   ld;
    logic [16:0]        dtry;
    logic               dge;
    logic [63:0]        prod;
    logic [63:0]        sh;
    logic [33:0]        rexp;
    logic [FL_W-1:0]    fl_dec;

    always_comb begin
        n_in_kind = r_in_kind;
        n_in_idx  = r_in_idx;
        n_in_val  = r_in_val;
        n_in_mode = r_in_mode;
        n_in_blk  = r_in_blk;
        n_cur     = r_cur;
        n_tgt     = r_tgt;
        n_fl      = r_fl;
        n_frames  = r_frames;
        n_start   = r_start;
        n_wr      = r_wr;
        n_logm    = r_logm;
        n_neg     = r_neg;
        n_phase   = r_phase;
        n_lc      = r_lc;
        n_lt      = r_lt;
        n_m       = r_m;
        n_frac    = r_frac;
        n_e       = r_e;
        n_dnum    = r_dnum;
        n_drem    = r_drem;
        n_cnt     = r_cnt;
        n_p       = r_p;

        retgt  = (r_in_val != rd_ent.tgt);
        fl2    = retgt ? ((r_in_mode == MODE_NONE) ? '0 : r_ramp) : rd_ent.fl;
        tgt2   = retgt ? r_in_val : rd_ent.tgt;
        diff   = {r_tgt[31], r_tgt} - {r_cur[31], r_cur};
        mag    = diff[32] ? (33'd0 - diff) : diff;
        sq     = {32'b0, r_m} * {32'b0, r_m};
        sq_hi  = sq[63];
        lval   = {r_e, r_frac[29:0], sq_hi};
        e_t    = f_top_bit(r_tgt);
        ld     = (r_lt < r_lc) ? (r_lc - r_lt) : (r_lt - r_lc);
        dtry   = {r_drem, r_dnum[NUM_W-1]};
        dge    = (dtry >= {1'b0, r_fl});
        prod   = {32'b0, r_p} * {32'b0, FAC_TAB[r_cnt[4:0]]};
        sh     = {32'b0, r_p} << r_lc[LOG_W-1:31];
        rexp   = 34'((sh + 64'h2000_0000) >> 30);
        fl_dec = r_fl - FL_W'(r_frames);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_in_kind = i_item.kind;
                    n_in_idx  = i_item.control_index;
                    n_in_val  = i_item.published_value;
                    n_in_mode = t_mode'(i_item.smoothing_mode);
                    n_in_blk  = i_item.block_frames;
                end
            end
            S_READ: begin
                n_start = rd_ent.cur;
                n_logm  = 1'b0;
                if (r_in_kind == KIND_SNAP) begin
                    n_start = r_in_val;
                    n_cur   = r_in_val;
                    n_tgt   = r_in_val;
                    n_fl    = '0;
                    n_wr    = 1'b1;
                end else if ((r_in_blk == '0) ||
                             (r_in_blk > BLK_W'(MAX_BLOCK_FRAMES))) begin
                    // rejected block: report, leave the entry alone
                    n_cur = rd_ent.cur;
                    n_tgt = rd_ent.tgt;
                    n_fl  = rd_ent.fl;
                    n_wr  = 1'b0;
                end else begin
                    n_wr  = 1'b1;
                    n_tgt = tgt2;
                    n_fl  = fl2;
                    n_cur = (fl2 == '0) ? tgt2 : rd_ent.cur;
                    n_frames = (FL_W'(r_in_blk) < fl2) ? r_in_blk : BLK_W'(fl2);
                    n_logm = (r_in_mode == MODE_LOG) &&
                             !rd_ent.cur[31] && (rd_ent.cur != '0) &&
                             !tgt2[31] && (tgt2 != '0);
                    n_e     = f_top_bit(rd_ent.cur);
                    n_m     = rd_ent.cur << (5'd31 - f_top_bit(rd_ent.cur));
                    n_phase = 1'b0;
                    n_cnt   = '0;
                end
            end
            S_LIN: begin
                n_neg  = diff[32];
                n_dnum = NUM_W'(mag) * NUM_W'(r_frames);
                n_drem = '0;
                n_cnt  = '0;
            end
            S_LOG: begin
                // one squaring per cycle; overflow past 2.0 gives a fraction bit
                n_m    = sq_hi ? sq[63:32] : sq[62:31];
                n_frac = {r_frac[29:0], sq_hi};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(30)) begin
                    n_cnt = '0;
                    if (!r_phase) begin
                        n_lc    = lval;
                        n_phase = 1'b1;
                        n_e     = e_t;
                        n_m     = r_tgt << (5'd31 - e_t);
                    end else begin
                        n_lt = lval;
                    end
                end
            end
            S_LMUL: begin
                n_neg  = (r_lt < r_lc);
                n_dnum = NUM_W'(ld * {36'b0, r_frames});
                n_drem = '0;
                n_cnt  = '0;
            end
            S_DIV: begin
                // restoring division by frames left, one quotient bit a cycle
                n_drem = dge ? 16'(dtry - {1'b0, r_fl}) : dtry[FL_W-1:0];
                n_dnum = {r_dnum[NUM_W-2:0], dge};
                n_cnt  = r_cnt + 1'b1;
            end
            S_POST: begin
                n_cnt = '0;
                n_p   = 32'h4000_0000;
                if (r_logm) begin
                    n_lc = r_neg ? (r_lc - r_dnum[LOG_W-1:0])
                                 : (r_lc + r_dnum[LOG_W-1:0]);
                end else begin
                    n_cur = r_neg ? (r_cur - r_dnum[31:0]) : (r_cur + r_dnum[31:0]);
                end
            end
            S_EXP: begin
                if (r_lc[5'd30 - r_cnt[4:0]]) begin
                    n_p = prod[61:30];
                end
                n_cnt = r_cnt + 1'b1;
            end
            S_EXPF: begin
                if (rexp == '0) begin
                    n_cur = 32'd1;
                end else if (rexp > 34'h07FFF_FFFF) begin
                    n_cur = 32'h7FFF_FFFF;
                end else begin
                    n_cur = rexp[31:0];
                end
            end
            S_UPD: begin
                n_fl = fl_dec;
                if (fl_dec == '0) begin
                    n_cur = r_tgt;
                end
            end
            S_FIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_kind <= n_in_kind;
        r_in_idx  <= n_in_idx;
        r_in_val  <= n_in_val;
        r_in_mode <= n_in_mode;
        r_in_blk  <= n_in_blk;
        r_cur     <= n_cur;
        r_tgt     <= n_tgt;
        r_fl      <= n_fl;
        r_frames  <= n_frames;
        r_start   <= n_start;
        r_wr      <= n_wr;
        r_logm    <= n_logm;
        r_neg     <= n_neg;
        r_phase   <= n_phase;
        r_lc      <= n_lc;
        r_lt      <= n_lt;
        r_m       <= n_m;
        r_frac    <= n_frac;
        r_e       <= n_e;
        r_dnum    <= n_dnum;
        r_drem    <= n_drem;
        r_cnt     <= n_cnt;
        r_p       <= n_p;
    end

    // ---------------- result beat register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_go) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_o_start <= r_start;
            r_o_end   <= r_cur;
            r_o_ramp  <= (r_fl != '0);
        end
    end

    // no item beat is taken while reset is held
    assign i_item.ready           = (r_state == S_IDLE) && i_rst_n;
    assign o_result.valid         = r_out_vld;
    assign o_result.start_value   = r_o_start;
    assign o_result.end_value     = r_o_end;
    assign o_result.still_ramping = r_o_ramp;

    // ---------------- assertions ----------------
    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> r_out_vld)
        else $error("result beat not loaded at finish");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(NUM_W)))
        else $error("divider count overrun");

    a_ramp_end_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && r_wr && (r_fl == '0)) |-> (r_cur == r_tgt))
        else $error("finished ramp not at target");

    a_log_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXPF) |=> ((r_cur != '0) && !r_cur[31]))
        else $error("log ramp result out of range");

endmodule

`default_nettype wire
